### hdl/session_slot_replay_table_assert.svh
// Assertion macros shared by the control and datapath modules.
`ifndef SESSION_SLOT_REPLAY_TABLE_ASSERT_SVH
`define SESSION_SLOT_REPLAY_TABLE_ASSERT_SVH

// same-cycle implication
`define SSRT_ASSERT_NOW(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error("assertion failed");

// next-cycle implication
`define SSRT_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("assertion failed");

`endif

### hdl/ssrt_pkg.sv
`default_nettype none
package ssrt_pkg;

   typedef enum logic [1:0] {
      REQ_ACQUIRE  = 2'd0,
      REQ_CAPTURE  = 2'd1,
      REQ_FINALIZE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      PHASE_UNUSED = 2'd0,
      PHASE_BUSY   = 2'd1,
      PHASE_DONE   = 2'd2,
      PHASE_CACHED = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADSLOT  = 2'd1,
      ST_MISORDER = 2'd2,
      ST_UNCACHED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_SLOTS_IN_USE = 2'd0,
      CSR_MAX_REPLY    = 2'd1,
      CSR_MAX_CACHE    = 2'd2
   } csr_reg_type;

   localparam logic [6:0]  SLOTS_IN_USE_RESET = 7'd64;
   localparam logic [23:0] MAX_REPLY_RESET    = 24'hFFFFFF;
   localparam logic [31:0] MAX_CACHE_RESET    = 32'hFFFFFFFF;
   localparam logic [31:0] FIRST_SEQUENCE     = 32'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] slot_index;
      logic [31:0] sequence_id;
      logic        cache_wanted;
      logic [23:0] reply_length;
      logic        session_gone;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        is_replay;
      logic [23:0] replay_length;
      logic [23:0] freed_length;
      logic        capture_taken;
      logic [31:0] bytes_used;
   } rsp_payload_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] pending;
      logic        requested;
      logic [23:0] stored_len;
   } slot_entry_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } ctrl_status_type;

endpackage
`default_nettype wire

### hdl/ssrt_ram.sv
`default_nettype none
module ssrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/ssrt_ctrl.sv
`default_nettype none
module ssrt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ssrt_pkg::ctrl_status_type stat,
   output ssrt_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign cmd.clear_step = (state_ff == S_CLEAR);
   assign cmd.load       = req_ready && req_valid;
   assign cmd.exec       = (state_ff == S_EXEC) && !stat.rsp_busy;

`include "session_slot_replay_table_assert.svh"

   `SSRT_ASSERT_NEXT(a_load_exec, clock, reset, cmd.load, state_ff == S_EXEC)
   `SSRT_ASSERT_NEXT(a_exec_done, clock, reset, cmd.exec, req_ready)
   `SSRT_ASSERT_NEXT(a_clear_end, clock, reset, cmd.clear_step && stat.clear_last, req_ready)

endmodule
`default_nettype wire

### hdl/ssrt_datapath.sv
`default_nettype none
module ssrt_datapath #(
   parameter int SLOT_COUNT = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ssrt_pkg::ctrl_cmd_type    cmd,
   output ssrt_pkg::ctrl_status_type      stat,
   input  wire ssrt_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ssrt_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [31:0]               csr_data
);

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [31:0] SLOT_LIMIT = 32'(SLOT_COUNT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);
   localparam int EW = $bits(ssrt_pkg::slot_entry_type);

   logic [6:0]  slots_in_use_ff;
   logic [23:0] max_reply_ff;
   logic [31:0] max_cache_ff;
   logic [31:0] bytes_used_ff, bytes_used_in;
   logic [AW-1:0] clr_addr_ff;
   ssrt_pkg::req_payload_type req_ff;
   logic        slot_ok_ff;
   logic        rsp_valid_ff;
   ssrt_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [EW-1:0] entry_rd_raw, entry_wr_raw;
   logic [31:0]   last_rd;
   ssrt_pkg::slot_entry_type entry_rd, entry_wr;
   logic        entry_we, last_we;
   logic [AW-1:0] entry_waddr;
   logic        slot_ok;

   assign csr_ready = 1'b1;
   assign slot_ok = (req_payload.slot_index < {25'd0, slots_in_use_ff}) &&
                    (req_payload.slot_index < SLOT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= ssrt_pkg::SLOTS_IN_USE_RESET;
         max_reply_ff    <= ssrt_pkg::MAX_REPLY_RESET;
         max_cache_ff    <= ssrt_pkg::MAX_CACHE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ssrt_pkg::CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_data[6:0];
            ssrt_pkg::CSR_MAX_REPLY:    max_reply_ff    <= csr_data[23:0];
            ssrt_pkg::CSR_MAX_CACHE:    max_cache_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         bytes_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + AW'(1);
         bytes_used_ff <= bytes_used_in;
         rsp_valid_ff  <= cmd.exec || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff     <= req_payload;
         slot_ok_ff <= slot_ok;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign entry_rd = ssrt_pkg::slot_entry_type'(entry_rd_raw);

   always_comb begin
      logic [32:0] cap_sum;
      logic        cached_hit;
      entry_wr      = entry_rd;
      last_we       = 1'b0;
      bytes_used_in = bytes_used_ff;
      rsp_in        = '0;
      cap_sum       = {1'b0, bytes_used_ff} + {9'd0, req_ff.reply_length};
      cached_hit    = (entry_rd.phase == ssrt_pkg::PHASE_CACHED) && (entry_rd.stored_len != '0);
      if (cmd.exec) begin
         case (req_ff.req_type)
            ssrt_pkg::REQ_ACQUIRE: begin
               if (!slot_ok_ff) begin
                  rsp_in.status = ssrt_pkg::ST_BADSLOT;
               end else if (entry_rd.phase == ssrt_pkg::PHASE_UNUSED) begin
                  if (req_ff.sequence_id != ssrt_pkg::FIRST_SEQUENCE) begin
                     rsp_in.status = ssrt_pkg::ST_MISORDER;
                  end else begin
                     entry_wr.phase     = ssrt_pkg::PHASE_BUSY;
                     entry_wr.pending   = req_ff.sequence_id;
                     entry_wr.requested = req_ff.cache_wanted;
                  end
               end else if (entry_rd.phase == ssrt_pkg::PHASE_BUSY) begin
                  rsp_in.status = (req_ff.sequence_id == entry_rd.pending) ?
                                  ssrt_pkg::ST_UNCACHED : ssrt_pkg::ST_MISORDER;
               end else if (req_ff.sequence_id == last_rd + ssrt_pkg::FIRST_SEQUENCE) begin
                  if (cached_hit) begin
                     rsp_in.freed_length = entry_rd.stored_len;
                     bytes_used_in = (bytes_used_ff >= {8'd0, entry_rd.stored_len}) ?
                                     bytes_used_ff - {8'd0, entry_rd.stored_len} : '0;
                     entry_wr.stored_len = '0;
                  end
                  entry_wr.phase     = ssrt_pkg::PHASE_BUSY;
                  entry_wr.pending   = req_ff.sequence_id;
                  entry_wr.requested = req_ff.cache_wanted;
               end else if (req_ff.sequence_id == last_rd) begin
                  if (cached_hit) begin
                     rsp_in.is_replay     = 1'b1;
                     rsp_in.replay_length = entry_rd.stored_len;
                  end else begin
                     rsp_in.status = ssrt_pkg::ST_UNCACHED;
                  end
               end else begin
                  rsp_in.status = ssrt_pkg::ST_MISORDER;
               end
            end
            ssrt_pkg::REQ_CAPTURE: begin
               if (slot_ok_ff && entry_rd.phase == ssrt_pkg::PHASE_BUSY &&
                   entry_rd.requested && entry_rd.stored_len == '0 &&
                   req_ff.reply_length != '0 && req_ff.reply_length <= max_reply_ff &&
                   cap_sum <= {1'b0, max_cache_ff}) begin
                  entry_wr.stored_len  = req_ff.reply_length;
                  bytes_used_in        = cap_sum[31:0];
                  rsp_in.capture_taken = 1'b1;
               end
            end
            ssrt_pkg::REQ_FINALIZE: begin
               if (slot_ok_ff && !req_ff.session_gone &&
                   entry_rd.phase == ssrt_pkg::PHASE_BUSY) begin
                  last_we          = 1'b1;
                  entry_wr.pending = '0;
                  entry_wr.phase   = (entry_rd.stored_len != '0) ?
                                     ssrt_pkg::PHASE_CACHED : ssrt_pkg::PHASE_DONE;
               end
            end
            default: ;
         endcase
      end
      rsp_in.bytes_used = bytes_used_in;
   end

   assign entry_we     = cmd.clear_step || (cmd.exec && slot_ok_ff);
   assign entry_waddr  = cmd.clear_step ? clr_addr_ff : req_ff.slot_index[AW-1:0];
   assign entry_wr_raw = cmd.clear_step ? '0 : EW'(entry_wr);

   ssrt_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_waddr),
      .wr_data (entry_wr_raw),
      .rd_en   (cmd.load),
      .rd_addr (req_payload.slot_index[AW-1:0]),
      .rd_data (entry_rd_raw)
   );

   ssrt_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .wr_addr (req_ff.slot_index[AW-1:0]),
      .wr_data (entry_rd.pending),
      .rd_en   (cmd.load),
      .rd_addr (req_payload.slot_index[AW-1:0]),
      .rd_data (last_rd)
   );

   assign stat.clear_last = (clr_addr_ff == LAST_ADDR);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

`include "session_slot_replay_table_assert.svh"

   `SSRT_ASSERT_NEXT(a_exec_rsp, clock, reset, cmd.exec,
                     rsp_valid_ff && rsp_ff.bytes_used == bytes_used_ff)
   `SSRT_ASSERT_NOW(a_last_we, clock, reset, last_we,
                    entry_we && req_ff.req_type == ssrt_pkg::REQ_FINALIZE)

endmodule
`default_nettype wire

### hdl/session_slot_replay_table.sv
// A taken request is registered and executes once the result register is free.
// One request at a time: the next is taken after the read then write-back of the
// slot entry memory; an unread result holds the block in execute until taken.
// Reset: synchronous, active high; a clearing pass over all SLOT_COUNT addresses then
// zeroes every slot entry, with requests held off and configuration writes taken.
`default_nettype none
module session_slot_replay_table #(
   parameter int SLOT_COUNT = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire ssrt_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ssrt_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [31:0]               csr_data
);

   ssrt_pkg::ctrl_cmd_type    cmd;
   ssrt_pkg::ctrl_status_type stat;

   ssrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssrt_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule
`default_nettype wire

### test/session_slot_replay_table_tb.sv
`default_nettype none
module session_slot_replay_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssrt_pkg::*;

   localparam int SLOTS = 64;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   class reply_cache_tracker;
      logic [6:0]      slot_limit;
      logic [23:0]     reply_cap;
      logic [31:0]     total_cap;
      phase_type       phase[SLOTS];
      logic [31:0]     last_seq[SLOTS];
      logic [31:0]     pend_seq[SLOTS];
      logic            wanted[SLOTS];
      logic [23:0]     held_len[SLOTS];
      logic [31:0]     bytes_held;
      rsp_payload_type pending_replies[$];
      int unsigned     mismatches;

      function new();
         slot_limit = SLOTS_IN_USE_RESET;
         reply_cap = MAX_REPLY_RESET;
         total_cap = MAX_CACHE_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            phase[i] = PHASE_UNUSED;
            last_seq[i] = '0;
            pend_seq[i] = '0;
            wanted[i] = 1'b0;
            held_len[i] = '0;
         end
         bytes_held = '0;
         mismatches = 0;
      endfunction

      function int unsigned live_slots();
         return (slot_limit > SLOTS) ? SLOTS : slot_limit;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_SLOTS_IN_USE: slot_limit = data[6:0];
            CSR_MAX_REPLY: reply_cap = data[23:0];
            CSR_MAX_CACHE: total_cap = data;
            default: ;
         endcase
      endfunction

      function void open_slot(int s, req_payload_type r);
         phase[s] = PHASE_BUSY;
         pend_seq[s] = r.sequence_id;
         wanted[s] = r.cache_wanted;
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type e;
         logic hit;
         int s;
         e = '0;
         hit = r.slot_index < live_slots();
         s = hit ? int'(r.slot_index) : 0;
         case (r.req_type)
            REQ_ACQUIRE: begin
               if (!hit) begin
                  e.status = ST_BADSLOT;
               end else if (phase[s] == PHASE_UNUSED) begin
                  if (r.sequence_id != FIRST_SEQUENCE)
                     e.status = ST_MISORDER;
                  else
                     open_slot(s, r);
               end else if (phase[s] == PHASE_BUSY) begin
                  e.status = (r.sequence_id == pend_seq[s]) ? ST_UNCACHED : ST_MISORDER;
               end else if (r.sequence_id == last_seq[s] + 32'd1) begin
                  if (phase[s] == PHASE_CACHED && held_len[s] != '0) begin
                     e.freed_length = held_len[s];
                     bytes_held = (bytes_held >= held_len[s]) ? bytes_held - held_len[s] : '0;
                     held_len[s] = '0;
                  end
                  open_slot(s, r);
               end else if (r.sequence_id == last_seq[s]) begin
                  if (phase[s] == PHASE_CACHED && held_len[s] != '0) begin
                     e.is_replay = 1'b1;
                     e.replay_length = held_len[s];
                  end else begin
                     e.status = ST_UNCACHED;
                  end
               end else begin
                  e.status = ST_MISORDER;
               end
            end
            REQ_CAPTURE: begin
               if (hit && phase[s] == PHASE_BUSY && wanted[s] && held_len[s] == '0 &&
                   r.reply_length != '0 && r.reply_length <= reply_cap &&
                   {1'b0, bytes_held} + {9'b0, r.reply_length} <= {1'b0, total_cap}) begin
                  held_len[s] = r.reply_length;
                  bytes_held = bytes_held + r.reply_length;
                  e.capture_taken = 1'b1;
               end
            end
            REQ_FINALIZE: begin
               if (hit && !r.session_gone && phase[s] == PHASE_BUSY) begin
                  last_seq[s] = pend_seq[s];
                  pend_seq[s] = '0;
                  phase[s] = (held_len[s] != '0) ? PHASE_CACHED : PHASE_DONE;
               end
            end
            default: ;
         endcase
         e.bytes_used = bytes_held;
         pending_replies.push_back(e);
      endfunction

      function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_reply(rsp_payload_type got);
         rsp_payload_type e;
         if (pending_replies.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none actual 0x%0h",
                     $time, got);
            mismatches++;
            return;
         end
         e = pending_replies.pop_front();
         compare_field("status", e.status, got.status);
         compare_field("is_replay", e.is_replay, got.is_replay);
         compare_field("replay_length", e.replay_length, got.replay_length);
         compare_field("freed_length", e.freed_length, got.freed_length);
         compare_field("capture_taken", e.capture_taken, got.capture_taken);
         compare_field("bytes_used", e.bytes_used, got.bytes_used);
      endfunction
   endclass

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [31:0]     csr_data = '0;

   int send_gap = 15;
   int rsp_gap = 59;
   int cycle_count = 0;
   reply_cache_tracker tracker;

   session_slot_replay_table #(.SLOT_COUNT(SLOTS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_gap);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.set_register(csr_index, csr_data);
         if (req_valid && req_ready)
            tracker.note_request(req_payload);
         if (rsp_valid && rsp_ready)
            tracker.check_reply(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("session_slot_replay_table regression: fail");
         $finish;
      end
   end

   function automatic req_payload_type make_item(logic [1:0] kind, logic [31:0] idx,
                                                 logic [31:0] seq, logic want,
                                                 logic [23:0] len, logic gone);
      req_payload_type r;
      r.req_type = kind;
      r.slot_index = idx;
      r.sequence_id = seq;
      r.cache_wanted = want;
      r.reply_length = len;
      r.session_gone = gone;
      return r;
   endfunction

   function automatic logic [23:0] pick_length();
      int unsigned p;
      logic [31:0] w;
      p = $urandom_range(99);
      w = $urandom;
      if (p < 8)
         return '0;
      if (p < 14)
         return w[23:0];
      if (p < 18)
         return tracker.reply_cap;
      return 24'($urandom_range(400, 1));
   endfunction

   function automatic req_payload_type next_slot_request();
      req_payload_type r;
      int unsigned lim;
      int unsigned pick;
      int s;
      r.req_type = REQ_ACQUIRE;
      r.slot_index = $urandom;
      r.sequence_id = $urandom;
      r.cache_wanted = ($urandom_range(99) < 70);
      r.reply_length = pick_length();
      r.session_gone = ($urandom_range(99) < 6);
      lim = tracker.live_slots();
      pick = $urandom_range(99);
      if (lim == 0 || pick < 15) begin
         r.req_type = 2'($urandom_range(3));
         r.session_gone = 1'($urandom_range(1));
         case ($urandom_range(2))
            0: r.slot_index = $urandom_range(lim + 2);
            1: r.slot_index = $urandom_range(70);
            default: ;
         endcase
         return r;
      end
      s = $urandom_range(lim - 1);
      r.slot_index = s;
      pick = $urandom_range(99);
      case (tracker.phase[s])
         PHASE_UNUSED: begin
            if (pick < 85)
               r.sequence_id = FIRST_SEQUENCE;
         end
         PHASE_BUSY: begin
            if (pick < 45)
               r.req_type = REQ_CAPTURE;
            else if (pick < 85)
               r.req_type = REQ_FINALIZE;
            else if (pick < 93)
               r.sequence_id = tracker.pend_seq[s];
         end
         default: begin
            if (pick < 55)
               r.sequence_id = tracker.last_seq[s] + 32'd1;
            else if (pick < 80)
               r.sequence_id = tracker.last_seq[s];
            else if (pick < 88)
               r.sequence_id = tracker.last_seq[s] + $urandom_range(4, 2);
            else if (pick < 94)
               r.req_type = REQ_FINALIZE;
            else
               r.req_type = REQ_CAPTURE;
         end
      endcase
      return r;
   endfunction

   task automatic send_request(input req_payload_type r);
      while ($urandom_range(99) < send_gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [6:0] slots, input logic [23:0] reply_max,
                            input logic [31:0] cache_max);
      write_register(CSR_SLOTS_IN_USE, {25'b0, slots});
      write_register(CSR_MAX_REPLY, {8'b0, reply_max});
      write_register(CSR_MAX_CACHE, cache_max);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 || $urandom_range(99) == 0)
            drain_replies();
         send_request(next_slot_request());
      end
   endtask

   initial begin
      tracker = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      configure(7'd4, 24'd1000, 32'd1500);
      send_request(make_item(REQ_ACQUIRE, 0, 1, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 0, 1, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 0, 7, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_CAPTURE, 0, 0, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_CAPTURE, 0, 0, 1'b0, 24'd1001, 1'b0));
      send_request(make_item(REQ_CAPTURE, 0, 0, 1'b0, 24'd1000, 1'b0));
      send_request(make_item(REQ_CAPTURE, 0, 0, 1'b0, 24'd5, 1'b0));
      send_request(make_item(REQ_FINALIZE, 0, 0, 1'b0, 24'd0, 1'b1));
      send_request(make_item(REQ_FINALIZE, 0, 0, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_FINALIZE, 0, 0, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 0, 1, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 1, 2, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 1, 1, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_CAPTURE, 1, 0, 1'b0, 24'd600, 1'b0));
      send_request(make_item(REQ_CAPTURE, 1, 0, 1'b0, 24'd500, 1'b0));
      send_request(make_item(REQ_FINALIZE, 1, 0, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 0, 2, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_CAPTURE, 0, 0, 1'b0, 24'd10, 1'b0));
      send_request(make_item(REQ_FINALIZE, 0, 0, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 0, 2, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 0, 0, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 4, 1, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_ACQUIRE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF,
                             1'b1));
      send_request(make_item(REQ_CAPTURE, 4, 0, 1'b1, 24'd3, 1'b0));
      send_request(make_item(REQ_FINALIZE, 32'hFFFFFFFF, 0, 1'b0, 24'd0, 1'b0));
      send_request(make_item(REQ_UNKNOWN, 1, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 1'b1));
      send_request(make_item(REQ_ACQUIRE, 3, 32'hFFFFFFFF, 1'b1, 24'd0, 1'b0));
      send_request(make_item(REQ_CAPTURE, 1, 0, 1'b1, 24'hFFFFFF, 1'b0));

      drain_replies();
      configure(7'd64, 24'hFFFFFF, 32'hFFFFFFFF);
      run_random(220);

      drain_replies();
      send_gap = 59;
      rsp_gap = 15;
      configure(7'd127, 24'd300, 32'd2000);
      run_random(200);

      drain_replies();
      send_gap = 0;
      rsp_gap = 0;
      configure(7'd12, 24'd0, 32'hFFFFFFFF);
      run_random(40);

      drain_replies();
      configure(7'd0, 24'd1, 32'd0);
      run_random(20);

      drain_replies();
      configure(7'd9, 24'hFFFFFF, 32'd3000);
      run_random(130);

      drain_replies();
      repeat (8) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
         $display("session_slot_replay_table regression: pass");
      end else begin
         $display("session_slot_replay_table regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/ssrt_pkg.sv
hdl/ssrt_ram.sv
hdl/ssrt_ctrl.sv
hdl/ssrt_datapath.sv
hdl/session_slot_replay_table.sv
test/session_slot_replay_table_tb.sv
